/* rtl/tcaa_pkg.sv */
`timescale 1ns / 1ps

package tcaa_pkg;

  localparam int QUEUE_DEPTH    = 32;
  localparam int MAX_REQUESTERS = 64;
  localparam int MAX_RESULTS    = 17;

  localparam int ID_W   = $clog2(MAX_REQUESTERS);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);
  localparam int CNT_W  = 5;
  localparam int WAIT_W = 1 + ID_W;

  localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(4);

  // action codes
  localparam logic ACT_ARRIVE = 1'b0;
  localparam logic ACT_DEPART = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_QUEUED = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_NO_OCC = 2'd3;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic capture;
    logic first;
    logic grant;
    logic check;
  } cmd_t;

  typedef struct packed {
    logic more;
  } sts_t;

  function automatic logic may_enter(logic cls, cnt_t c0, cnt_t c1, cnt_t cap);
    cnt_t own;
    cnt_t other;
    own   = cls ? c1 : c0;
    other = cls ? c0 : c1;
    return (other == '0) && (own < cap);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

/* rtl/tcaa_ram.sv */
`timescale 1ns / 1ps

module tcaa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tcaa_ctrl.sv */
`timescale 1ns / 1ps

module tcaa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  tcaa_pkg::sts_t sts,
  output tcaa_pkg::cmd_t cmd
);
  import tcaa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIRST = 6'b000010,
    S_SEND  = 6'b000100,
    S_GRANT = 6'b001000,
    S_LOOK  = 6'b010000,
    S_CHECK = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_SEND);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_FIRST;
        end
      end
      S_FIRST: begin
        cmd.first = 1'b1;
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (out_tready) begin
          state_nxt = sts.more ? S_GRANT : S_IDLE;
        end
      end
      S_GRANT: begin
        cmd.grant = 1'b1;
        state_nxt = S_LOOK;
      end
      // new head address settles in the RAM read register
      S_LOOK: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = S_SEND;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_grant_after_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && sts.more) |=> (state_r == S_GRANT))
    else $error("cascade grant not started after result with more pending");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !sts.more) |=> in_tready)
    else $error("controller did not return to idle after final result");

endmodule

/* rtl/tcaa_dp.sv */
`timescale 1ns / 1ps

module tcaa_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [4:0]                cfg_wr_data,
  input  logic                      in_action,
  input  logic                      in_class,
  input  logic [tcaa_pkg::ID_W-1:0] in_id,
  input  tcaa_pkg::cmd_t            cmd,
  output tcaa_pkg::sts_t            sts,
  output logic                      out_granted,
  output logic                      out_class,
  output logic [tcaa_pkg::ID_W-1:0] out_id,
  output logic [1:0]                out_status,
  output logic                      out_last
);
  import tcaa_pkg::*;

  cnt_t              capacity_r;
  cnt_t              c0_r, c0_nxt;
  cnt_t              c1_r, c1_nxt;
  logic [PTR_W-1:0]  head_r, tail_r;
  logic [FILL_W-1:0] fill_r;
  logic [RES_W-1:0]  nres_r;
  logic              more_r;

  logic              act_r, cls_r;
  logic [ID_W-1:0]   id_r;

  logic              granted_r, gcls_r, last_r;
  logic [ID_W-1:0]   gid_r;
  logic [1:0]        status_r;

  logic [WAIT_W-1:0] rd_data;
  logic              hd_cls;
  logic [ID_W-1:0]   hd_id;

  logic              own_may, enq, queue_full;
  cnt_t              own_cnt;
  logic              f_granted;
  logic [1:0]        f_status;

  assign hd_cls = rd_data[WAIT_W-1];
  assign hd_id  = rd_data[ID_W-1:0];

  assign own_may    = may_enter(cls_r, c0_r, c1_r, capacity_r);
  assign own_cnt    = cls_r ? c1_r : c0_r;
  assign queue_full = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign enq        = cmd.first && (act_r == ACT_ARRIVE) && !own_may && !queue_full;

  tcaa_ram #(.WIDTH(WAIT_W), .DEPTH(QUEUE_DEPTH)) u_wait (
    .clk   (clk),
    .we    (enq),
    .waddr (tail_r),
    .wdata ({cls_r, id_r}),
    .raddr (head_r),
    .rdata (rd_data)
  );

  // outcome of the item itself and the counts after it
  always_comb begin
    c0_nxt    = c0_r;
    c1_nxt    = c1_r;
    f_granted = 1'b0;
    f_status  = ST_OK;
    if (act_r == ACT_ARRIVE) begin
      if (own_may) begin
        f_granted = 1'b1;
        if (cls_r) c1_nxt = c1_r + CNT_W'(1);
        else       c0_nxt = c0_r + CNT_W'(1);
      end else if (queue_full) begin
        f_status = ST_FULL;
      end else begin
        f_status = ST_QUEUED;
      end
    end else begin
      if (own_cnt == '0) begin
        f_status = ST_NO_OCC;
      end else if (cls_r) begin
        c1_nxt = c1_r - CNT_W'(1);
      end else begin
        c0_nxt = c0_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
      c0_r       <= '0;
      c1_r       <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      fill_r     <= '0;
      nres_r     <= '0;
      more_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity_r <= cfg_wr_data;
      end
      if (cmd.first) begin
        c0_r   <= c0_nxt;
        c1_r   <= c1_nxt;
        nres_r <= RES_W'(1);
        // a freshly queued head cannot pass: counts did not change
        more_r <= (fill_r != '0) && may_enter(hd_cls, c0_nxt, c1_nxt, capacity_r);
        if (enq) begin
          tail_r <= ptr_inc(tail_r);
          fill_r <= fill_r + FILL_W'(1);
        end
      end
      if (cmd.grant) begin
        if (hd_cls) c1_r <= c1_r + CNT_W'(1);
        else        c0_r <= c0_r + CNT_W'(1);
        head_r <= ptr_inc(head_r);
        fill_r <= fill_r - FILL_W'(1);
        nres_r <= nres_r + RES_W'(1);
      end
      if (cmd.check) begin
        more_r <= (nres_r < RES_W'(MAX_RESULTS)) && (fill_r != '0)
                  && may_enter(hd_cls, c0_r, c1_r, capacity_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action;
      cls_r <= in_class;
      id_r  <= in_id;
    end
    if (cmd.first) begin
      granted_r <= f_granted;
      gcls_r    <= f_granted ? cls_r : 1'b0;
      gid_r     <= f_granted ? id_r : '0;
      status_r  <= f_status;
      last_r    <= !((fill_r != '0) && may_enter(hd_cls, c0_nxt, c1_nxt, capacity_r));
    end
    if (cmd.grant) begin
      granted_r <= 1'b1;
      gcls_r    <= hd_cls;
      gid_r     <= hd_id;
      status_r  <= ST_OK;
    end
    if (cmd.check) begin
      last_r <= !((nres_r < RES_W'(MAX_RESULTS)) && (fill_r != '0)
                  && may_enter(hd_cls, c0_r, c1_r, capacity_r));
    end
  end

  assign sts.more    = more_r;
  assign out_granted = granted_r;
  assign out_class   = gcls_r;
  assign out_id      = gid_r;
  assign out_status  = status_r;
  assign out_last    = last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(QUEUE_DEPTH))
    else $error("wait queue fill beyond depth");

  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !((c0_r != '0) && (c1_r != '0)))
    else $error("both classes present at once");

  a_grant_pops: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.grant |=> (fill_r == $past(fill_r) - FILL_W'(1)) && granted_r)
    else $error("cascade grant did not pop the queue head");

endmodule

/* rtl/two_class_capacity_admission_arbiter_top.sv */
`timescale 1ns / 1ps

// Two-class admission arbiter for a shared resource of limited capacity.
// Input channel in_*: one item per request. in_tuser is the action
// (0 arrival, 1 departure); in_tdata carries the class and requester id.
// Each item yields one or more result items on out_*; out_tlast marks the
// final one. The first result reports the item's own outcome (direct grant,
// queued, queue full, or departure of an absent class). Further results are
// grants of queued requesters, taken from the head of a 32-entry FIFO while
// the head is compatible and there is room, at most 17 results per item.
// After an item is accepted its outcome is registered in S_FIRST and the first
// result is shown in S_SEND; each further grant passes S_GRANT, S_LOOK and
// S_CHECK before S_SEND, paced by the registered read of the FIFO RAM at the
// new head. One item is in flight at a time; the next waits for the last result.
// cfg_wr_en writes the capacity register (reset 4) in any cycle; write it
// only while idle. Synchronous reset clears counts and queue pointers; the
// FIFO RAM is not cleared. While out_tready is low the result holds and no
// new item is accepted.
module two_class_capacity_admission_arbiter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] person_class, [6:1] requester_id, [7] zero
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] granted_class, [6:1] granted_id, [8:7] status
  output logic        out_tuser,  // [0] granted
  output logic        out_tlast
);
  import tcaa_pkg::*;

  cmd_t            cmd;
  sts_t            sts;
  logic            o_class;
  logic [ID_W-1:0] o_id;
  logic [1:0]      o_status;

  tcaa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tcaa_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_action   (in_tuser),
    .in_class    (in_tdata[0]),
    .in_id       (in_tdata[ID_W:1]),
    .cmd         (cmd),
    .sts         (sts),
    .out_granted (out_tuser),
    .out_class   (o_class),
    .out_id      (o_id),
    .out_status  (o_status),
    .out_last    (out_tlast)
  );

  assign out_tdata = {7'd0, o_status, o_id, o_class};

endmodule

/* tb/admission_grant_checker.sv */
`timescale 1ns / 1ps

module admission_grant_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] person_class, [6:1] requester_id, [7] zero
  input  logic        in_tuser,   // [0] action
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [0] granted_class, [6:1] granted_id, [8:7] status
  input  logic        out_tuser,  // [0] granted
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);
  import tcaa_pkg::*;

  typedef struct packed {
    logic            granted;
    logic            cls;
    logic [ID_W-1:0] id;
    logic [1:0]      status;
    logic            last;
  } admit_res_t;

  admit_res_t      expected_grants [$];
  int              fail_total = 0;

  cnt_t            capacity;
  cnt_t            occ [2];
  logic            wq_cls [QUEUE_DEPTH];
  logic [ID_W-1:0] wq_id  [QUEUE_DEPTH];
  int              wq_head;
  int              wq_tail;
  int              wq_fill;

  task automatic report_mismatch(string what, int got, int want);
    fail_total++;
    // keep the log bounded if the block is badly broken
    if (fail_total <= 40)
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  function automatic logic has_room(logic c);
    return (occ[~c] == '0) && (occ[c] < capacity);
  endfunction

  task automatic predict_admission(logic act, logic cls, logic [ID_W-1:0] id);
    admit_res_t batch [$];
    admit_res_t r;
    logic       hc;
    if (act == ACT_ARRIVE) begin
      if (has_room(cls)) begin
        occ[cls] = occ[cls] + 1'b1;
        batch.push_back('{1'b1, cls, id, ST_OK, 1'b0});
      end else if (wq_fill >= QUEUE_DEPTH) begin
        batch.push_back('{1'b0, 1'b0, '0, ST_FULL, 1'b0});
      end else begin
        wq_cls[wq_tail] = cls;
        wq_id[wq_tail]  = id;
        wq_tail = (wq_tail == QUEUE_DEPTH - 1) ? 0 : wq_tail + 1;
        wq_fill++;
        batch.push_back('{1'b0, 1'b0, '0, ST_QUEUED, 1'b0});
      end
    end else begin
      if (occ[cls] == '0) begin
        batch.push_back('{1'b0, 1'b0, '0, ST_NO_OCC, 1'b0});
      end else begin
        occ[cls] = occ[cls] - 1'b1;
        batch.push_back('{1'b0, 1'b0, '0, ST_OK, 1'b0});
      end
    end
    // baton passing: admit queue heads while compatible, bounded per item
    while (batch.size() < MAX_RESULTS && wq_fill > 0) begin
      hc = wq_cls[wq_head];
      if (!has_room(hc)) break;
      occ[hc] = occ[hc] + 1'b1;
      batch.push_back('{1'b1, hc, wq_id[wq_head], ST_OK, 1'b0});
      wq_head = (wq_head == QUEUE_DEPTH - 1) ? 0 : wq_head + 1;
      wq_fill--;
    end
    r = batch.pop_back();
    r.last = 1'b1;
    batch.push_back(r);
    foreach (batch[i]) expected_grants.push_back(batch[i]);
  endtask

  always @(posedge clk) begin
    admit_res_t want;
    if (!rst_n) begin
      capacity = CAPACITY_RESET;
      occ[0]   = '0;
      occ[1]   = '0;
      wq_head  = 0;
      wq_tail  = 0;
      wq_fill  = 0;
      expected_grants.delete();
    end else begin
      if (cfg_wr_en) capacity = cfg_wr_data;
      // results first: one seen at the same edge belongs to an older item
      if (out_tvalid && out_tready) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("unexpected result, tdata", out_tdata, 0);
        end else begin
          want = expected_grants.pop_front();
          if (out_tuser !== want.granted)
            report_mismatch("granted", out_tuser, want.granted);
          if (out_tdata[0] !== want.cls)
            report_mismatch("granted_class", out_tdata[0], want.cls);
          if (out_tdata[6:1] !== want.id)
            report_mismatch("granted_id", out_tdata[6:1], want.id);
          if (out_tdata[8:7] !== want.status)
            report_mismatch("status", out_tdata[8:7], want.status);
          if (out_tdata[15:9] !== 7'd0)
            report_mismatch("tdata padding", out_tdata[15:9], 0);
          if (out_tlast !== want.last)
            report_mismatch("last", out_tlast, want.last);
        end
      end
      if (in_tvalid && in_tready)
        predict_admission(in_tuser, in_tdata[0], in_tdata[6:1]);
    end
    fail_count <= fail_total;
    pending    <= expected_grants.size();
  end

endmodule

/* tb/tb_two_class_capacity_admission_arbiter_top.sv */
`timescale 1ns / 1ps

module tb_two_class_capacity_admission_arbiter_top;
  import tcaa_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [4:0]  cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;  // [0] person_class, [6:1] requester_id, [7] zero
  logic        in_tuser    = 1'b0; // [0] action
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;         // [0] granted_class, [6:1] granted_id, [8:7] status
  logic        out_tuser;         // [0] granted
  logic        out_tlast;

  int          fail_count;
  int          pending;
  int          stall_cycles;
  logic        calm      = 1'b0;  // no idling on either side while set
  logic        cur_class = 1'b0;

  two_class_capacity_admission_arbiter_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  admission_grant_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 33);
  end

  task automatic send_item(logic act, logic cls, logic [ID_W-1:0] id);
    if (!calm) begin
      while ($urandom_range(99) < 33) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {1'b0, id, cls};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random(int depart_pct, int stick_pct);
    if ($urandom_range(99) >= stick_pct) cur_class = ~cur_class;
    send_item(($urandom_range(99) < depart_pct) ? ACT_DEPART : ACT_ARRIVE,
              cur_class, ID_W'($urandom_range(63)));
  endtask

  // lower valid, wait for every outstanding result, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(logic [4:0] cap);
    cfg_wr_data <= cap;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_phase(logic [4:0] cap, int n, int depart_pct, int stick_pct);
    set_capacity(cap);
    repeat (n) send_random(depart_pct, stick_pct);
    drain();
  endtask

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, at the reset capacity of four
    send_item(ACT_ARRIVE, 1'b0, 6'd0);
    send_item(ACT_ARRIVE, 1'b0, 6'd63);
    send_item(ACT_ARRIVE, 1'b1, 6'd21);   // other class inside: waits
    send_item(ACT_DEPART, 1'b1, 6'd0);    // no woman inside
    send_item(ACT_ARRIVE, 1'b0, 6'd3);
    send_item(ACT_ARRIVE, 1'b0, 6'd4);    // at capacity
    send_item(ACT_ARRIVE, 1'b0, 6'd5);    // full: queued behind the woman
    send_item(ACT_DEPART, 1'b0, 6'd42);   // head is incompatible, nothing moves
    send_item(ACT_DEPART, 1'b0, 6'd0);
    send_item(ACT_DEPART, 1'b0, 6'd0);
    send_item(ACT_DEPART, 1'b0, 6'd0);    // empty: head woman admitted, man still waits
    send_item(ACT_ARRIVE, 1'b1, 6'd42);   // enters at once, overtaking the waiting man
    send_item(ACT_DEPART, 1'b1, 6'd0);
    send_item(ACT_DEPART, 1'b1, 6'd0);    // waiting man admitted
    send_item(ACT_DEPART, 1'b0, 6'd0);
    send_item(ACT_DEPART, 1'b0, 6'd0);    // no man inside
    drain();

    // capacity zero: everything waits until the queue overflows
    cur_class = 1'b1;
    run_phase(5'd0, 34, 0, 100);
    // the first item can then release the longest cascade
    run_phase(5'd16, 20, 45, 80);
    calm = 1'b1;
    run_phase(5'd31, 30, 50, 70);
    calm = 1'b0;
    run_phase(5'd1, 30, 50, 60);
    run_phase(5'd2, 30, 45, 70);
    repeat (2) run_phase(5'($urandom_range(16, 2)), 30, 50, 70);

    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
rtl/tcaa_pkg.sv
rtl/tcaa_ram.sv
rtl/tcaa_ctrl.sv
rtl/tcaa_dp.sv
rtl/two_class_capacity_admission_arbiter_top.sv
tb/admission_grant_checker.sv
tb/tb_two_class_capacity_admission_arbiter_top.sv
